/* sv/awsc_pkg.sv */
package awsc_pkg;

  localparam int SPEED_W      = 16;
  localparam int ANGLE_W      = 16;
  localparam int LEN_W        = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 33;
  localparam int PROD_W       = 52;
  localparam int MAG_W        = 52;
  localparam int NORM_W       = 31;
  localparam int SH_W         = 5;
  localparam int SPD_MAG_W    = 17;
  localparam int ROOT_STEPS   = 32;
  localparam int SQ_W         = 64;
  localparam int ROOT_W       = 32;
  localparam int MUL_W        = 49;
  localparam int DIV_W        = 50;
  localparam int DIV_BITS     = 15;
  localparam int LANE_LAT     = 2 + ROOT_STEPS + 2 + DIV_BITS;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd24576;
  localparam logic [SPEED_W-1:0]        SPEED_MAX   = 16'd32767;
  localparam logic [LEN_W-1:0]          WHEELBASE_RESET = 16'd256;
  localparam logic [LEN_W-1:0]          TRACK_RESET     = 16'd256;

  localparam logic [7:0] CFG_WHEELBASE = 8'd0;
  localparam logic [7:0] CFG_TRACK     = 8'd1;

  typedef struct packed {
    logic                      zero;
    logic signed [SPEED_W-1:0] speed;
  } tag_t;

  function automatic logic signed [CW-1:0] step_angle(input int i);
    logic signed [CW-1:0] a;
    a = '0;
    case (i)
      0: a = 33'sd843314857;
      1: a = 33'sd497837829;
      2: a = 33'sd263043837;
      3: a = 33'sd133525159;
      4: a = 33'sd67021687;
      5: a = 33'sd33543516;
      6: a = 33'sd16775851;
      7: a = 33'sd8388437;
      8: a = 33'sd4194283;
      9: a = 33'sd2097149;
      default: a[30-i] = 1'b1;
    endcase
    return a;
  endfunction

endpackage

/* sv/awsc_cordic.sv */
module awsc_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  awsc_pkg::tag_t              in_tag,
  input  logic signed [awsc_pkg::CW-1:0] in_z,
  output logic                        out_valid,
  output awsc_pkg::tag_t              out_tag,
  output logic signed [awsc_pkg::CW-1:0] out_x,
  output logic signed [awsc_pkg::CW-1:0] out_y
);
  import awsc_pkg::*;

  logic                 v_r   [0:CORDIC_STEPS-1];
  tag_t                 tag_r [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] x_r   [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] y_r   [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] z_r   [0:CORDIC_STEPS-1];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic                 v_src;
    tag_t                 tag_src;
    logic signed [CW-1:0] x_src, y_src, z_src;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

    if (k == 0) begin : g_first
      assign v_src   = in_valid;
      assign tag_src = in_tag;
      assign x_src   = 33'sd1073741824;
      assign y_src   = '0;
      assign z_src   = in_z;
    end else begin : g_rest
      assign v_src   = v_r[k-1];
      assign tag_src = tag_r[k-1];
      assign x_src   = x_r[k-1];
      assign y_src   = y_r[k-1];
      assign z_src   = z_r[k-1];
    end

    always_comb begin
      if (!z_src[CW-1]) begin
        x_nxt = x_src - (y_src >>> k);
        y_nxt = y_src + (x_src >>> k);
        z_nxt = z_src - step_angle(k);
      end else begin
        x_nxt = x_src + (y_src >>> k);
        y_nxt = y_src - (x_src >>> k);
        z_nxt = z_src + step_angle(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_src;
        x_r[k]   <= x_nxt;
        y_r[k]   <= y_nxt;
        z_r[k]   <= z_nxt;
      end
    end
  end

  assign out_valid = v_r[CORDIC_STEPS-1];
  assign out_tag   = tag_r[CORDIC_STEPS-1];
  assign out_x     = x_r[CORDIC_STEPS-1];
  assign out_y     = y_r[CORDIC_STEPS-1];

endmodule

/* sv/awsc_wheel.sv */
module awsc_wheel (
  input  logic                             clk,
  input  logic                             en,
  input  logic [awsc_pkg::NORM_W-1:0]      side_a,
  input  logic [awsc_pkg::NORM_W-1:0]      side_b,
  input  logic [awsc_pkg::NORM_W-1:0]      den,
  input  logic [awsc_pkg::SPD_MAG_W-1:0]   mag,
  output logic [awsc_pkg::SPEED_W-1:0]     speed,
  output logic                             sat
);
  import awsc_pkg::*;

  logic [SQ_W-1:0]      sqa_r, sqb_r, sum_r;
  logic [NORM_W-1:0]    den0_r, den1_r;
  logic [SPD_MAG_W-1:0] mag0_r, mag1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r  <= SQ_W'(side_a) * SQ_W'(side_a);
      sqb_r  <= SQ_W'(side_b) * SQ_W'(side_b);
      den0_r <= den;
      mag0_r <= mag;
      sum_r  <= sqa_r + sqb_r;
      den1_r <= den0_r;
      mag1_r <= mag0_r;
    end
  end

  logic [SQ_W-1:0]      rn_r   [0:ROOT_STEPS-1];
  logic [SQ_W-1:0]      rres_r [0:ROOT_STEPS-1];
  logic [NORM_W-1:0]    rden_r [0:ROOT_STEPS-1];
  logic [SPD_MAG_W-1:0] rmag_r [0:ROOT_STEPS-1];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0]      n_src, res_src, trial;
    logic [NORM_W-1:0]    den_src;
    logic [SPD_MAG_W-1:0] mag_src;

    if (k == 0) begin : g_first
      assign n_src   = sum_r;
      assign res_src = '0;
      assign den_src = den1_r;
      assign mag_src = mag1_r;
    end else begin : g_rest
      assign n_src   = rn_r[k-1];
      assign res_src = rres_r[k-1];
      assign den_src = rden_r[k-1];
      assign mag_src = rmag_r[k-1];
    end

    assign trial = res_src + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_src >= trial) begin
          rn_r[k]   <= n_src - trial;
          rres_r[k] <= (res_src >> 1) + BIT;
        end else begin
          rn_r[k]   <= n_src;
          rres_r[k] <= res_src >> 1;
        end
        rden_r[k] <= den_src;
        rmag_r[k] <= mag_src;
      end
    end
  end

  logic [MUL_W-1:0]  prod_r;
  logic [NORM_W-1:0] den2_r;
  logic [DIV_W-1:0]  num_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_W'(rmag_r[ROOT_STEPS-1]) * MUL_W'(rres_r[ROOT_STEPS-1][ROOT_W-1:0]);
      den2_r <= rden_r[ROOT_STEPS-1];
    end
  end

  assign num_nxt = DIV_W'(prod_r) + DIV_W'(den2_r >> 1);

  logic [DIV_W-1:0]    rem_r [0:DIV_BITS];
  logic [DIV_BITS-1:0] q_r   [0:DIV_BITS];
  logic                sat_r [0:DIV_BITS];
  logic [NORM_W-1:0]   dd_r  [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_nxt;
      q_r[0]   <= '0;
      sat_r[0] <= num_nxt >= (DIV_W'(den2_r) << DIV_BITS);
      dd_r[0]  <= den2_r;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    logic [DIV_W-1:0] sub;
    assign sub = DIV_W'(dd_r[k]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[k] >= sub) begin
          rem_r[k+1]  <= rem_r[k] - sub;
          q_r[k+1]    <= q_r[k] | (DIV_BITS'(1) << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          q_r[k+1]    <= q_r[k];
        end
        sat_r[k+1] <= sat_r[k];
        dd_r[k+1]  <= dd_r[k];
      end
    end
  end

  assign sat   = sat_r[DIV_BITS];
  assign speed = sat_r[DIV_BITS] ? SPEED_MAX : SPEED_W'(q_r[DIV_BITS]);

endmodule

/* sv/ackermann_wheel_speeds_core.sv */
// Four-wheel speed kinematics for a steered vehicle. A beat carries the vehicle speed and the
// steering angle; one result beat follows per input beat with the four wheel speeds and a
// saturation flag. The datapath is fully pipelined and takes one beat every cycle while the
// skid stage is empty. Each beat passes the 30-step angle rotator, then the 32-step square
// root and the 15-step divider in each wheel lane. A two-entry output register and skid
// stage let the input keep flowing while a result waits; the pipeline holds only when both are
// full. Configuration writes are always ready and should be made while no beats are in flight.
module ackermann_wheel_speeds_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // vehicle_speed [15:0], steering_angle [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // left_front, right_front, left_rear, right_rear speeds
  output logic [0:0]  out_tuser,  // saturated_flag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import awsc_pkg::*;

  logic [LEN_W-1:0] wb_r, track_r;
  logic             en;
  logic             skid_v_r, out_v_r;

  assign cfg_ready = 1'b1;
  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r    <= WHEELBASE_RESET;
      track_r <= TRACK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WHEELBASE: wb_r    <= cfg_data;
        CFG_TRACK:     track_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [ANGLE_W-1:0] ang, ang_c;
  logic                      s0_v_r;
  tag_t                      s0_tag_r;
  logic signed [CW-1:0]      s0_z_r;

  assign ang   = $signed(in_tdata[31:16]);
  assign ang_c = (ang > ANGLE_LIMIT) ? ANGLE_LIMIT :
                 (ang < -ANGLE_LIMIT) ? -ANGLE_LIMIT : ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tag_r.zero  <= (ang == '0);
      s0_tag_r.speed <= $signed(in_tdata[15:0]);
      s0_z_r         <= {ang_c[ANGLE_W-1], ang_c, 16'b0};
    end
  end

  logic                 c_v;
  tag_t                 c_tag;
  logic signed [CW-1:0] c_x, c_y, x_cl;

  awsc_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_v_r),
    .in_tag   (s0_tag_r),
    .in_z     (s0_z_r),
    .out_valid(c_v),
    .out_tag  (c_tag),
    .out_x    (c_x),
    .out_y    (c_y)
  );

  logic [LEN_W+1:0] l2;
  assign l2   = (wb_r == '0) ? 18'd2 : {1'b0, wb_r, 1'b0};
  assign x_cl = (c_x < 33'sd1) ? 33'sd1 : c_x;

  logic                     p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r;
  tag_t                     p1_tag_r, p2_tag_r, p3_tag_r, p4_tag_r, p5_tag_r;
  logic signed [PROD_W-1:0] d_r, p_r, e_r, qr, ql;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= c_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tag_r <= c_tag;
      d_r      <= $signed({1'b0, l2}) * x_cl;
      p_r      <= $signed({1'b0, track_r}) * c_y;
      e_r      <= $signed({1'b0, l2}) * c_y;
    end
  end

  assign qr = d_r - p_r;
  assign ql = d_r + p_r;

  logic [MAG_W-1:0]     md_r, me_r, mr_r, ml_r;
  logic [MAG_W-1:0]     md3_r, me3_r, mr3_r, ml3_r, m_r;
  logic [MAG_W-1:0]     md4_r, me4_r, mr4_r, ml4_r;
  logic [SPD_MAG_W-1:0] mag2_r, mag3_r, mag4_r, mag5_r;
  logic [MAG_W-1:0]     m_a, m_b;
  logic [SH_W-1:0]      sh_nxt, sh_r;
  logic [NORM_W-1:0]    nd_r, ne_r, nr_r, nl_r;
  logic [MAG_W-1:0]     nd_w;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_tag_r <= p1_tag_r;
      md_r     <= MAG_W'(d_r);
      me_r     <= e_r[PROD_W-1] ? MAG_W'(-e_r) : MAG_W'(e_r);
      mr_r     <= qr[PROD_W-1] ? MAG_W'(-qr) : MAG_W'(qr);
      ml_r     <= ql[PROD_W-1] ? MAG_W'(-ql) : MAG_W'(ql);
      mag2_r   <= p1_tag_r.speed[SPEED_W-1] ?
                  SPD_MAG_W'(-SPD_MAG_W'($signed(p1_tag_r.speed))) :
                  SPD_MAG_W'(p1_tag_r.speed);
    end
  end

  assign m_a = (md_r > me_r) ? md_r : me_r;
  assign m_b = (mr_r > ml_r) ? mr_r : ml_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_tag_r <= p2_tag_r;
      md3_r    <= md_r;
      me3_r    <= me_r;
      mr3_r    <= mr_r;
      ml3_r    <= ml_r;
      mag3_r   <= mag2_r;
      m_r      <= (m_a > m_b) ? m_a : m_b;
    end
  end

  always_comb begin
    sh_nxt = '0;
    for (int b = NORM_W; b < MAG_W; b++) begin
      if (m_r[b]) sh_nxt = SH_W'(b - NORM_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_tag_r <= p3_tag_r;
      md4_r    <= md3_r;
      me4_r    <= me3_r;
      mr4_r    <= mr3_r;
      ml4_r    <= ml3_r;
      mag4_r   <= mag3_r;
      sh_r     <= sh_nxt;
    end
  end

  assign nd_w = md4_r >> sh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_tag_r <= p4_tag_r;
      mag5_r   <= mag4_r;
      nd_r     <= (nd_w == '0) ? NORM_W'(1) : nd_w[NORM_W-1:0];
      ne_r     <= NORM_W'(me4_r >> sh_r);
      nr_r     <= NORM_W'(mr4_r >> sh_r);
      nl_r     <= NORM_W'(ml4_r >> sh_r);
    end
  end

  logic [SPEED_W-1:0] w_lf, w_rf, w_lr, w_rr;
  logic               s_lf, s_rf, s_lr, s_rr;

  awsc_wheel u_lf (
    .clk(clk), .en(en), .side_a(ne_r), .side_b(nl_r), .den(nd_r), .mag(mag5_r),
    .speed(w_lf), .sat(s_lf)
  );
  awsc_wheel u_rf (
    .clk(clk), .en(en), .side_a(ne_r), .side_b(nr_r), .den(nd_r), .mag(mag5_r),
    .speed(w_rf), .sat(s_rf)
  );
  awsc_wheel u_lr (
    .clk(clk), .en(en), .side_a('0), .side_b(nl_r), .den(nd_r), .mag(mag5_r),
    .speed(w_lr), .sat(s_lr)
  );
  awsc_wheel u_rr (
    .clk(clk), .en(en), .side_a('0), .side_b(nr_r), .den(nd_r), .mag(mag5_r),
    .speed(w_rr), .sat(s_rr)
  );

  logic [LANE_LAT-1:0] lv_r;
  tag_t                ltag_r [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (en) begin
      lv_r <= {lv_r[LANE_LAT-2:0], p5_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ltag_r[0] <= p5_tag_r;
      for (int k = 1; k < LANE_LAT; k++) ltag_r[k] <= ltag_r[k-1];
    end
  end

  logic        t_v_r, t_sat_r, skid_sat_r, out_sat_r;
  logic [63:0] t_data_r, skid_data_r, out_data_r;
  tag_t        ltag_last;

  assign ltag_last = ltag_r[LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (en) begin
      t_v_r <= lv_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ltag_last.zero) begin
        t_data_r <= {4{ltag_last.speed}};
        t_sat_r  <= 1'b0;
      end else begin
        t_data_r <= {w_rr, w_lr, w_rf, w_lf};
        t_sat_r  <= s_lf | s_rf | s_lr | s_rr;
      end
    end
  end

  logic out_free, tail_take;
  assign out_free  = !out_v_r || out_tready;
  assign tail_take = en && t_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_r <= skid_v_r || tail_take;
      end
      if (skid_v_r && out_free) begin
        skid_v_r <= 1'b0;
      end else if (tail_take && !out_free) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_v_r ? skid_data_r : t_data_r;
      out_sat_r  <= skid_v_r ? skid_sat_r : t_sat_r;
    end
    if (tail_take && !out_free) begin
      skid_data_r <= t_data_r;
      skid_sat_r  <= t_sat_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a pending output beat");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled while the output was free");

  a_sat_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (!out_tdata[15] && !out_tdata[31] &&
                                      !out_tdata[47] && !out_tdata[63]))
    else $error("saturated beat carries a negative wheel speed");

endmodule
